FILE: src/occ_pkg.sv
// Package for the offline command coalescer: operation and message codes,
// register indexes, pipeline types and the saturating accumulate function.
// No dependencies; every other file of the block imports it.
`default_nettype none

package occ_pkg;

  typedef enum logic [3:0] {
    OP_ONOFF      = 4'd0,
    OP_LEVEL_STEP = 4'd1,
    OP_LEVEL_MOVE = 4'd2,
    OP_LEVEL_STOP = 4'd3,
    OP_CT_STEP    = 4'd4,
    OP_CT_MOVE    = 4'd5,
    OP_CT_STOP    = 4'd6,
    OP_FLUSH      = 4'd7,
    OP_CLEAR      = 4'd8
  } op_e;

  localparam logic [1:0] MSG_ONOFF = 2'd0;
  localparam logic [1:0] MSG_LEVEL = 2'd1;
  localparam logic [1:0] MSG_CT    = 2'd2;

  localparam logic [2:0] CFG_LEVEL_STEP = 3'd0;
  localparam logic [2:0] CFG_CT_STEP    = 3'd1;
  localparam logic [2:0] CFG_LEVEL_RATE = 3'd2;
  localparam logic [2:0] CFG_CT_RATE    = 3'd3;
  localparam logic [2:0] CFG_CT_RANGE   = 3'd4;

  localparam int TIME_W   = 32;
  localparam int RATE_W   = 16;
  // Elapsed time is clipped to this width: any rate of at least one then
  // already drives the quotient past its cap.
  localparam int EL_W     = 21;
  localparam int PROD_W   = RATE_W + EL_W;
  localparam int AMT_W    = 11;
  localparam int RANGE_W  = 10;
  localparam int LEVEL_W  = 9;

  // Quotients of 2048 or more by 1000 are capped at 2047.
  localparam logic [PROD_W-1:0] SAT_PRODUCT = PROD_W'(2048000);
  localparam logic [AMT_W-1:0]  DELTA_CAP   = {AMT_W{1'b1}};
  // Exact division by 1000 of values below 2^21: multiply, shift by 31.
  localparam int                RECIP_W     = 22;
  localparam logic [RECIP_W-1:0] DIV_RECIP  = RECIP_W'(2147484);
  localparam int                DIV_SHIFT   = 31;

  localparam logic [RANGE_W-1:0] LEVEL_CLAMP = RANGE_W'(254);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_MSGS   = 3;

  typedef struct packed {
    op_e  op;
    logic dir;
    logic onoff_ok;
    logic level_ok;
    logic ct_ok;
    logic fire;
    logic up;
  } stg_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic                    switch_on;
    logic signed [AMT_W-1:0] amount;
    logic                    last;
  } msg_t;

  // Adds or subtracts a magnitude and clamps symmetrically to +/-lim.
  function automatic logic signed [AMT_W-1:0] sat_add(
    input logic signed [AMT_W-1:0] acc,
    input logic [AMT_W-1:0]        mag,
    input logic                    up,
    input logic [RANGE_W-1:0]      lim
  );
    logic signed [AMT_W+1:0] sum;
    logic signed [AMT_W+1:0] hi;
    logic signed [AMT_W+1:0] res;
    hi = $signed({3'b000, lim});
    if (up) begin
      sum = $signed({{2{acc[AMT_W-1]}}, acc}) + $signed({2'b00, mag});
    end else begin
      sum = $signed({{2{acc[AMT_W-1]}}, acc}) - $signed({2'b00, mag});
    end
    if (sum > hi) begin
      res = hi;
    end else if (sum < -hi) begin
      res = -hi;
    end else begin
      res = sum;
    end
    return res[AMT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/occ_delta.sv
// Move delta unit: rate times elapsed milliseconds, divided by 1000 and
// capped at 2047, over two registered stages. Depends on occ_pkg.
`default_nettype none

module occ_delta (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [occ_pkg::EL_W-1:0]   el_i,
  input  wire logic [occ_pkg::RATE_W-1:0] rate_i,
  output logic      [occ_pkg::AMT_W-1:0]  q_o
);
  import occ_pkg::*;

  localparam int RP_W = EL_W + RECIP_W;

  logic [PROD_W-1:0] prod_d, prod_q;
  logic [RP_W-1:0]   recip_prod;
  logic [AMT_W-1:0]  q_d, q_q;

  assign prod_d = {{EL_W{1'b0}}, rate_i} * {{RATE_W{1'b0}}, el_i};

  assign recip_prod = {{RECIP_W{1'b0}}, prod_q[EL_W-1:0]} * {{EL_W{1'b0}}, DIV_RECIP};

  always_comb begin
    if (prod_q >= SAT_PRODUCT) begin
      q_d = DELTA_CAP;
    end else begin
      q_d = recip_prod[DIV_SHIFT +: AMT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      q_q    <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

FILE: src/occ_out_fifo.sv
// Result queue: takes up to three messages in one cycle and offers one per
// cycle, while not stalled, on the valid/stall output channel. Depends on occ_pkg.
`default_nettype none

module occ_out_fifo (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [1:0]                     push_n_i,
  input  wire occ_pkg::msg_t [occ_pkg::MAX_MSGS-1:0] push_i,
  output logic      [occ_pkg::FIFO_CNT_W-1:0] count_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output occ_pkg::msg_t                       head_o
);
  import occ_pkg::*;

  msg_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] rd_ptr_q, wr_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_ptr_q];
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_MSGS; k++) begin
      if (FIFO_CNT_W'(k) < FIFO_CNT_W'(push_n_i)) begin
        mem_q[wr_ptr_q + FIFO_PTR_W'(k)] <= push_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n_i);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(push_n_i) - FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: src/offline_command_coalescer.sv
// Offline command coalescer top level. An accepted request moves through the
// stages s1, s2 and s3, then its messages are offered from the result queue.
// Throughput: one request per cycle; a flush retires only when the four-entry
// queue has room for its messages, which drain one per cycle while the output
// is not stalled. Reset clears all slots, move trackers and the queue and loads
// the default register values. Depends on occ_pkg, occ_delta and occ_out_fifo.
`default_nettype none

module offline_command_coalescer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  op_i,
  input  wire logic        direction_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        onoff_sent_ok_i,
  input  wire logic        level_sent_ok_i,
  input  wire logic        ct_sent_ok_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       msg_kind_o,
  output logic             switch_on_o,
  output logic signed [10:0] step_amount_o,
  output logic             last_o
);
  import occ_pkg::*;

  // Configuration registers.
  logic [7:0]          level_step_q;
  logic [RANGE_W-1:0]  ct_step_q;
  logic [RATE_W-1:0]   level_rate_q, ct_rate_q;
  logic [RANGE_W-1:0]  ct_range_q;

  // Move trackers, updated when a request is accepted.
  logic              lvl_active_q, lvl_active_d, lvl_up_q, lvl_up_d;
  logic [TIME_W-1:0] lvl_start_q, lvl_start_d;
  logic              ct_active_q, ct_active_d, ct_up_q, ct_up_d;
  logic [TIME_W-1:0] ct_start_q, ct_start_d;

  // Slots, updated when a request retires from the last stage.
  logic                      sw_pend_q, sw_pend_d, sw_val_q, sw_val_d;
  logic signed [LEVEL_W-1:0] lvl_acc_q, lvl_acc_d;
  logic signed [AMT_W-1:0]   ct_acc_q, ct_acc_d;

  logic              v1_q, v2_q, v3_q;
  stg_t              s1_q, s2_q, s3_q, s1_d;
  logic [EL_W-1:0]   el_q;
  logic [RATE_W-1:0] rate_q;
  logic [TIME_W-1:0] el_raw;
  logic [RATE_W-1:0] rate_sel;
  logic [AMT_W-1:0]  q;

  logic                  en, accept, fits, retire;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [1:0]            push_n;
  msg_t [MAX_MSGS-1:0]   push;
  msg_t                  head;
  logic [2:0]            present;
  msg_t [MAX_MSGS-1:0]   cand;
  logic signed [AMT_W-1:0] lvl_wide;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_step_q <= 8'd32;
      ct_step_q    <= RANGE_W'(32);
      level_rate_q <= RATE_W'(100);
      ct_rate_q    <= RATE_W'(100);
      ct_range_q   <= RANGE_W'(347);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LEVEL_STEP: level_step_q <= cfg_data_i[7:0];
        CFG_CT_STEP:    ct_step_q    <= cfg_data_i[RANGE_W-1:0];
        CFG_LEVEL_RATE: level_rate_q <= cfg_data_i;
        CFG_CT_RATE:    ct_rate_q    <= cfg_data_i;
        CFG_CT_RANGE:   ct_range_q   <= cfg_data_i[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control. The whole pipeline moves together.
  assign present[0] = sw_pend_q;
  assign present[1] = (lvl_acc_q != '0);
  assign present[2] = (ct_acc_q != '0);

  always_comb begin
    push_n = '0;
    if (v3_q && s3_q.op == OP_FLUSH) begin
      push_n = 2'(present[0]) + 2'(present[1]) + 2'(present[2]);
    end
  end

  assign fits       = ({1'b0, fifo_cnt} + {{(FIFO_CNT_W - 1){1'b0}}, push_n})
                      <= (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign en         = !v3_q || fits;
  assign retire     = v3_q && fits;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  // First stage: move trackers and elapsed time.
  always_comb begin
    lvl_active_d = lvl_active_q;
    lvl_up_d     = lvl_up_q;
    lvl_start_d  = lvl_start_q;
    ct_active_d  = ct_active_q;
    ct_up_d      = ct_up_q;
    ct_start_d   = ct_start_q;
    s1_d.op       = op_e'(op_i);
    s1_d.dir      = direction_i;
    s1_d.onoff_ok = onoff_sent_ok_i;
    s1_d.level_ok = level_sent_ok_i;
    s1_d.ct_ok    = ct_sent_ok_i;
    s1_d.fire     = 1'b0;
    s1_d.up       = lvl_up_q;
    el_raw        = now_ms_i - lvl_start_q;
    rate_sel      = level_rate_q;
    case (op_e'(op_i))
      OP_LEVEL_MOVE: begin
        lvl_active_d = 1'b1;
        lvl_up_d     = direction_i;
        lvl_start_d  = now_ms_i;
      end
      OP_LEVEL_STOP: begin
        s1_d.fire    = lvl_active_q;
        lvl_active_d = 1'b0;
      end
      OP_CT_MOVE: begin
        ct_active_d = 1'b1;
        ct_up_d     = direction_i;
        ct_start_d  = now_ms_i;
      end
      OP_CT_STOP: begin
        s1_d.fire   = ct_active_q;
        s1_d.up     = ct_up_q;
        el_raw      = now_ms_i - ct_start_q;
        rate_sel    = ct_rate_q;
        ct_active_d = 1'b0;
      end
      OP_CLEAR: begin
        lvl_active_d = 1'b0;
        ct_active_d  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_active_q <= 1'b0;
      lvl_up_q     <= 1'b0;
      lvl_start_q  <= '0;
      ct_active_q  <= 1'b0;
      ct_up_q      <= 1'b0;
      ct_start_q   <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
    end else begin
      if (accept) begin
        lvl_active_q <= lvl_active_d;
        lvl_up_q     <= lvl_up_d;
        lvl_start_q  <= lvl_start_d;
        ct_active_q  <= ct_active_d;
        ct_up_q      <= ct_up_d;
        ct_start_q   <= ct_start_d;
      end
      if (en) begin
        v1_q <= accept;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= s1_d;
      s2_q   <= s1_q;
      s3_q   <= s2_q;
      rate_q <= rate_sel;
      el_q   <= (|el_raw[TIME_W-1:EL_W]) ? {EL_W{1'b1}} : el_raw[EL_W-1:0];
    end
  end

  occ_delta u_delta (
    .clk_i  (clk_i),
    .en_i   (en),
    .el_i   (el_q),
    .rate_i (rate_q),
    .q_o    (q)
  );

  // Last stage: slot updates and flush messages.
  assign lvl_wide = {{(AMT_W - LEVEL_W){lvl_acc_q[LEVEL_W-1]}}, lvl_acc_q};

  always_comb begin
    cand[0].kind      = MSG_ONOFF;
    cand[0].switch_on = sw_val_q;
    cand[0].amount    = '0;
    cand[0].last      = !present[1] && !present[2];
    cand[1].kind      = MSG_LEVEL;
    cand[1].switch_on = 1'b0;
    cand[1].amount    = lvl_wide;
    cand[1].last      = !present[2];
    cand[2].kind      = MSG_CT;
    cand[2].switch_on = 1'b0;
    cand[2].amount    = ct_acc_q;
    cand[2].last      = 1'b1;
  end

  always_comb begin
    logic [1:0] n;
    n    = '0;
    push = '0;
    for (int k = 0; k < MAX_MSGS; k++) begin
      if (present[k]) begin
        push[n] = cand[k];
        n       = n + 2'd1;
      end
    end
  end

  always_comb begin
    sw_pend_d = sw_pend_q;
    sw_val_d  = sw_val_q;
    lvl_acc_d = lvl_acc_q;
    ct_acc_d  = ct_acc_q;
    if (retire) begin
      case (s3_q.op)
        OP_ONOFF: begin
          sw_pend_d = 1'b1;
          sw_val_d  = s3_q.dir;
        end
        OP_LEVEL_STEP: begin
          lvl_acc_d = LEVEL_W'(sat_add(lvl_wide, {3'b000, level_step_q}, s3_q.dir,
                                       LEVEL_CLAMP));
        end
        OP_LEVEL_STOP: begin
          if (s3_q.fire) begin
            lvl_acc_d = LEVEL_W'(sat_add(lvl_wide, q, s3_q.up, LEVEL_CLAMP));
          end
        end
        OP_CT_STEP: begin
          ct_acc_d = sat_add(ct_acc_q, {1'b0, ct_step_q}, s3_q.dir, ct_range_q);
        end
        OP_CT_STOP: begin
          if (s3_q.fire) begin
            ct_acc_d = sat_add(ct_acc_q, q, s3_q.up, ct_range_q);
          end
        end
        OP_FLUSH: begin
          if (present[0] && s3_q.onoff_ok) begin
            sw_pend_d = 1'b0;
          end
          if (s3_q.level_ok) begin
            lvl_acc_d = '0;
          end
          if (s3_q.ct_ok) begin
            ct_acc_d = '0;
          end
        end
        OP_CLEAR: begin
          sw_pend_d = 1'b0;
          lvl_acc_d = '0;
          ct_acc_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_pend_q <= 1'b0;
      sw_val_q  <= 1'b0;
      lvl_acc_q <= '0;
      ct_acc_q  <= '0;
    end else begin
      sw_pend_q <= sw_pend_d;
      sw_val_q  <= sw_val_d;
      lvl_acc_q <= lvl_acc_d;
      ct_acc_q  <= ct_acc_d;
    end
  end

  occ_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (retire ? push_n : 2'd0),
    .push_i      (push),
    .count_o     (fifo_cnt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign msg_kind_o    = head.kind;
  assign switch_on_o   = head.switch_on;
  assign step_amount_o = head.amount;
  assign last_o        = head.last;

  // The result queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // The level slot stays within its clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_acc_q <= 9'sd254) && (lvl_acc_q >= -9'sd254))
    else $error("level slot out of range");

  // Input is held back only while a request waits in the last stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v3_q)
    else $error("stall without a waiting request");

  // A delivered on/off message empties its slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && s3_q.op == OP_FLUSH && s3_q.onoff_ok) |=> !sw_pend_q)
    else $error("on/off slot not cleared after delivery");

endmodule

`default_nettype wire
